// File: hdl/arcball_vector_map_top_defines.svh
// ----------------------------------------------------------------------------
// Arcball vector map assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ARCBALL_VECTOR_MAP_TOP_DEFINES_SVH
`define ARCBALL_VECTOR_MAP_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked property, skipped while reset is high.
`define AVM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked property that also holds during reset.
`define AVM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define AVM_ASSERT(lbl, prop, msg)
`define AVM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/avm_pkg.sv
// ----------------------------------------------------------------------------
// Arcball vector map package
// Widths, register indexes, stage types and the shared divide/root steps.
// ----------------------------------------------------------------------------
package avm_pkg;

   localparam int FRAC_BITS  = 14;
   localparam int COORD_BITS = 12;
   localparam int CFG_BITS   = 13;
   localparam int MAG_BITS   = 15;
   localparam int REM_BITS   = 30;
   localparam int DEN_BITS   = 16;
   localparam int STEPS      = 15;

   // Register indexes of the configuration port.
   localparam logic [0:0] CSR_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_HEIGHT = 1'b1;

   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd1600;
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd900;

   // One squared in the radicand scale (2*FRAC_BITS fraction bits).
   localparam logic [REM_BITS-1:0] ONE_SQ = 30'd1 << (2 * FRAC_BITS);

   // State of one restoring division lane pair.
   typedef struct packed {
      logic [REM_BITS-1:0] rx;
      logic [REM_BITS-1:0] ry;
      logic [MAG_BITS-1:0] qx;
      logic [MAG_BITS-1:0] qy;
      logic [DEN_BITS-1:0] dx;
      logic [DEN_BITS-1:0] dy;
      logic [MAG_BITS-1:0] zr;
      logic                sx;
      logic                sy;
      logic                on;
      logic                clip;
   } avm_div_type;

   // Normalized vector in sign and magnitude form.
   typedef struct packed {
      logic [MAG_BITS-1:0] ax;
      logic [MAG_BITS-1:0] ay;
      logic                sx;
      logic                sy;
      logic                clip;
   } avm_vec_type;

   // State of the square and square-root pipeline.
   typedef struct packed {
      logic [REM_BITS-1:0] sqx;
      logic [REM_BITS-1:0] sqy;
      logic [REM_BITS-1:0] rem;
      logic [MAG_BITS-1:0] root;
      logic [MAG_BITS-1:0] ax;
      logic [MAG_BITS-1:0] ay;
      logic                sx;
      logic                sy;
      logic                on;
      logic                clip;
   } avm_root_type;

   // Finished result.
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0]        z;
      logic               on;
      logic               clip;
   } avm_out_type;

   typedef struct packed {
      logic [REM_BITS-1:0] rem;
      logic                qb;
   } avm_step_type;

   // One restoring division step: try to take den << sh from the remainder.
   function automatic avm_step_type div_step(input logic [REM_BITS-1:0] rem,
                                             input logic [DEN_BITS-1:0] den,
                                             input int unsigned sh);
      logic [REM_BITS:0] t;
      avm_step_type      r;
      t = {15'd0, den} << sh;
      if ({1'b0, rem} >= t) begin
         r.rem = REM_BITS'({1'b0, rem} - t);
         r.qb  = 1'b1;
      end else begin
         r.rem = rem;
         r.qb  = 1'b0;
      end
      return r;
   endfunction

   // One digit of the integer square root; rem holds n minus root squared.
   function automatic avm_step_type sqrt_step(input logic [REM_BITS-1:0] rem,
                                              input logic [MAG_BITS-1:0] root,
                                              input int unsigned i);
      logic [REM_BITS:0] t;
      avm_step_type      r;
      t = ({16'd0, root} << (i + 1)) | ((REM_BITS + 1)'(1) << (2 * i));
      if ({1'b0, rem} >= t) begin
         r.rem = REM_BITS'({1'b0, rem} - t);
         r.qb  = 1'b1;
      end else begin
         r.rem = rem;
         r.qb  = 1'b0;
      end
      return r;
   endfunction

endpackage

// File: hdl/arcball_vector_map_top.sv
// ----------------------------------------------------------------------------
// Arcball vector map top level
// Maps a mouse pixel position to a Q2.14 arcball vector.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one mouse position per transfer; the rsp_
//   channel returns one arcball vector per request, in request order.
//   Screen width and height are written through the csr_ port while the
//   block is idle; a zero size acts as one pixel.
//   The item passes 50 register stages: 16 of screen division, 17 of
//   squaring and square root, 16 of length division and the output
//   register. One transfer is accepted every cycle while the pipeline
//   is not stalled.
//   The whole pipeline advances together; when the receiver holds
//   rsp_tready low with a result waiting, req_tready falls and every stage
//   keeps its contents, so nothing is lost or repeated.
//   Reset clears all valid bits and returns the screen size to 1600 x 900.
// ----------------------------------------------------------------------------
`include "arcball_vector_map_top_defines.svh"

module arcball_vector_map_top import avm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,   // mouse_x[11:0], mouse_y[23:12]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // vec_x[15:0], vec_y[31:16], vec_z[46:32], on_sphere[47], clipped[48], zero
   output logic [55:0]         rsp_tdata,
   input  logic                csr_wr_en,
   input  logic [0:0]          csr_index,
   input  logic [CFG_BITS-1:0] csr_wdata
);

   logic [CFG_BITS-1:0] width_ff;
   logic [CFG_BITS-1:0] height_ff;
   logic                adv;
   logic                norm_vld;
   avm_vec_type         norm_vec;
   logic                root_vld;
   avm_root_type        root_res;
   logic                out_vld;
   avm_out_type         out_res;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
         endcase
      end
   end

   // The pipeline moves whenever the output slot is free or being taken.
   assign adv        = rsp_tready || !out_vld;
   assign req_tready = adv;

   avm_norm u_norm (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_vld        (req_tvalid),
      .mouse_x       (req_tdata[11:0]),
      .mouse_y       (req_tdata[23:12]),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .out_vld       (norm_vld),
      .out_vec       (norm_vec)
   );

   avm_root u_root (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (norm_vld),
      .in_vec   (norm_vec),
      .out_vld  (root_vld),
      .out_root (root_res)
   );

   avm_rescale u_rescale (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (root_vld),
      .in_root (root_res),
      .out_vld (out_vld),
      .out_res (out_res)
   );

   assign rsp_tvalid = out_vld;
   assign rsp_tdata  = {7'd0, out_res.clip, out_res.on, out_res.z,
                        out_res.y, out_res.x};

   `AVM_ASSERT(a_off_sphere_z_zero, rsp_tvalid && !rsp_tdata[47] |-> rsp_tdata[46:32] == 15'd0, "z must be zero off the sphere")
   `AVM_ASSERT(a_x_range, rsp_tvalid |-> ($signed(rsp_tdata[15:0]) >= -16'sd16384) && ($signed(rsp_tdata[15:0]) <= 16'sd16384), "vec_x out of range")
   `AVM_ASSERT(a_ready_follows_stall, req_tready == (rsp_tready || !rsp_tvalid), "request ready does not track the output stall")
   `AVM_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> !rsp_tvalid, "result valid after reset")

endmodule

// File: hdl/avm_norm.sv
// ----------------------------------------------------------------------------
// Arcball vector map: screen normalization
// Clamps the mouse position and divides both axes by the screen size,
// one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module avm_norm import avm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_vld,
   input  logic [COORD_BITS-1:0] mouse_x,
   input  logic [COORD_BITS-1:0] mouse_y,
   input  logic [CFG_BITS-1:0]   screen_width,
   input  logic [CFG_BITS-1:0]   screen_height,
   output logic                  out_vld,
   output avm_vec_type           out_vec
);

   avm_div_type       st_ff [0:STEPS];
   avm_div_type       st_in [0:STEPS];
   logic [STEPS:0]    vld_ff;
   logic [STEPS:0]    vld_in;

   // Clamp, center and sign each axis, then run the division steps.
   always_comb begin
      logic [CFG_BITS-1:0]   w;
      logic [CFG_BITS-1:0]   h;
      logic [COORD_BITS-1:0] mx;
      logic [COORD_BITS-1:0] my;
      logic [CFG_BITS-1:0]   ax2;
      logic [CFG_BITS-1:0]   ay2;
      logic [CFG_BITS-1:0]   magx;
      logic [CFG_BITS-1:0]   magy;
      logic                  clip;
      avm_step_type          dx;
      avm_step_type          dy;
      w    = (screen_width == '0) ? CFG_BITS'(1) : screen_width;
      h    = (screen_height == '0) ? CFG_BITS'(1) : screen_height;
      clip = 1'b0;
      mx   = mouse_x;
      my   = mouse_y;
      if ({1'b0, mouse_x} > w) begin
         mx   = w[COORD_BITS-1:0];
         clip = 1'b1;
      end
      if ({1'b0, mouse_y} > h) begin
         my   = h[COORD_BITS-1:0];
         clip = 1'b1;
      end
      ax2  = {mx, 1'b0};
      ay2  = {my, 1'b0};
      magx = (ax2 >= w) ? ax2 - w : w - ax2;
      magy = (ay2 >= h) ? ay2 - h : h - ay2;

      st_in[0]      = '0;
      st_in[0].rx   = {3'd0, magx, 14'd0};
      st_in[0].ry   = {3'd0, magy, 14'd0};
      st_in[0].dx   = {3'd0, w};
      st_in[0].dy   = {3'd0, h};
      st_in[0].sx   = (ax2 < w) && (magx != '0);
      st_in[0].sy   = !(ay2 < h) && (magy != '0);
      st_in[0].clip = clip;

      for (int k = 1; k <= STEPS; k++) begin
         dx = div_step(st_ff[k-1].rx, st_ff[k-1].dx, STEPS - k);
         dy = div_step(st_ff[k-1].ry, st_ff[k-1].dy, STEPS - k);
         st_in[k]              = st_ff[k-1];
         st_in[k].rx           = dx.rem;
         st_in[k].ry           = dy.rem;
         st_in[k].qx[STEPS-k]  = dx.qb;
         st_in[k].qy[STEPS-k]  = dy.qb;
      end
   end

   assign vld_in = {vld_ff[STEPS-1:0], in_vld};

   // Valid bits travel with the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign out_vld      = vld_ff[STEPS];
   assign out_vec.ax   = st_ff[STEPS].qx;
   assign out_vec.ay   = st_ff[STEPS].qy;
   assign out_vec.sx   = st_ff[STEPS].sx;
   assign out_vec.sy   = st_ff[STEPS].sy;
   assign out_vec.clip = st_ff[STEPS].clip;

endmodule

// File: hdl/avm_root.sv
// ----------------------------------------------------------------------------
// Arcball vector map: squares and square root
// Squares both axes, forms the radicand for z or for the vector length,
// and extracts its root one bit per stage.
// ----------------------------------------------------------------------------
module avm_root import avm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_vld,
   input  avm_vec_type  in_vec,
   output logic         out_vld,
   output avm_root_type out_root
);

   localparam int LAST = STEPS + 1;

   avm_root_type    st_ff [0:LAST];
   avm_root_type    st_in [0:LAST];
   logic [LAST:0]   vld_ff;
   logic [LAST:0]   vld_in;

   always_comb begin
      logic [REM_BITS-1:0] s;
      avm_step_type        rs;
      // Stage of the two multipliers.
      st_in[0]      = '0;
      st_in[0].sqx  = REM_BITS'(in_vec.ax) * REM_BITS'(in_vec.ax);
      st_in[0].sqy  = REM_BITS'(in_vec.ay) * REM_BITS'(in_vec.ay);
      st_in[0].ax   = in_vec.ax;
      st_in[0].ay   = in_vec.ay;
      st_in[0].sx   = in_vec.sx;
      st_in[0].sy   = in_vec.sy;
      st_in[0].clip = in_vec.clip;

      // Inside the circle the root gives z, outside it gives the length.
      s             = st_ff[0].sqx + st_ff[0].sqy;
      st_in[1]      = st_ff[0];
      st_in[1].on   = (s <= ONE_SQ);
      st_in[1].rem  = (s <= ONE_SQ) ? ONE_SQ - s : s;
      st_in[1].root = '0;

      for (int k = 2; k <= LAST; k++) begin
         rs = sqrt_step(st_ff[k-1].rem, st_ff[k-1].root, LAST - k);
         st_in[k]                  = st_ff[k-1];
         st_in[k].rem              = rs.rem;
         st_in[k].root[LAST-k]     = rs.qb;
      end
   end

   assign vld_in = {vld_ff[LAST-1:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign out_vld  = vld_ff[LAST];
   assign out_root = st_ff[LAST];

endmodule

// File: hdl/avm_rescale.sv
// ----------------------------------------------------------------------------
// Arcball vector map: rescale and output
// Divides both axes by the vector length for points outside the circle and
// registers the finished result.
// ----------------------------------------------------------------------------
module avm_rescale import avm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_vld,
   input  avm_root_type in_root,
   output logic         out_vld,
   output avm_out_type  out_res
);

   avm_div_type       st_ff [0:STEPS];
   avm_div_type       st_in [0:STEPS];
   logic [STEPS+1:0]  vld_ff;
   logic [STEPS+1:0]  vld_in;
   avm_out_type       res_ff;
   avm_out_type       res_in;

   always_comb begin
      avm_step_type        dx;
      avm_step_type        dy;
      avm_div_type         f;
      logic [MAG_BITS:0]   mx;
      logic [MAG_BITS:0]   my;
      // Load the dividends; the root is the divisor.
      st_in[0]      = '0;
      st_in[0].rx   = {1'b0, in_root.ax, 14'd0};
      st_in[0].ry   = {1'b0, in_root.ay, 14'd0};
      st_in[0].dx   = {1'b0, in_root.root};
      st_in[0].dy   = {1'b0, in_root.root};
      st_in[0].qx   = in_root.ax;
      st_in[0].qy   = in_root.ay;
      st_in[0].zr   = in_root.root;
      st_in[0].sx   = in_root.sx;
      st_in[0].sy   = in_root.sy;
      st_in[0].on   = in_root.on;
      st_in[0].clip = in_root.clip;

      for (int k = 1; k <= STEPS; k++) begin
         dx = div_step(st_ff[k-1].rx, st_ff[k-1].dx, STEPS - k);
         dy = div_step(st_ff[k-1].ry, st_ff[k-1].dy, STEPS - k);
         st_in[k]      = st_ff[k-1];
         st_in[k].rx   = dx.rem;
         st_in[k].ry   = dy.rem;
         // On the sphere the magnitudes pass unchanged.
         if (!st_ff[k-1].on) begin
            st_in[k].qx[STEPS-k] = dx.qb;
            st_in[k].qy[STEPS-k] = dy.qb;
         end
      end

      // Restore signs and choose z.
      f           = st_ff[STEPS];
      mx          = {1'b0, f.qx};
      my          = {1'b0, f.qy};
      res_in.x    = f.sx ? -$signed(mx) : $signed(mx);
      res_in.y    = f.sy ? -$signed(my) : $signed(my);
      res_in.z    = f.on ? f.zr : '0;
      res_in.on   = f.on;
      res_in.clip = f.clip;
   end

   assign vld_in = {vld_ff[STEPS:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff  <= st_in;
         res_ff <= res_in;
      end
   end

   assign out_vld = vld_ff[STEPS+1];
   assign out_res = res_ff;

endmodule
